// File: rtl/strm_pkg.sv
// Shared types, constants and a helper function for the sparse-table range-minimum engine.
package strm_pkg;

  // Default sizes handed to the top level.
  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int LEVELS_DEF       = 11;
  localparam int VALUE_WIDTH_DEF  = 32;

  // Fixed field widths of the streams and the configuration port.
  localparam int OP_W   = 2;
  localparam int IDX_W  = 10;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 11;
  localparam int CNT_W  = 11;
  localparam int MIN_W  = 32;
  localparam int FLAG_W = 2;

  // Width of the log search input and result.
  localparam int SRCH_W = 17;
  localparam int LOG_W  = 5;

  // Operation codes carried in the input tuser.
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QDATA,
    ST_BSTART,
    ST_BRUN,
    ST_BDRAIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_we;
    logic query_issue;
    logic query_done;
    logic build_start;
    logic build_read;
    logic build_next;
    logic build_finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic build_empty;
    logic build_last_j;
    logic build_last_lvl;
  } stat_t;

  // Position of the highest set bit; zero for a zero input.
  function automatic logic [LOG_W-1:0] floor_log2(input logic [SRCH_W-1:0] v);
    logic [LOG_W-1:0] r;
    r = '0;
    for (int i = 0; i < SRCH_W; i++) begin
      if (v[i]) r = LOG_W'(i);
    end
    return r;
  endfunction

endpackage

// File: rtl/strm_ctrl.sv
// Controller state machine that sequences loads, queries and the table build.
module strm_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic [strm_pkg::OP_W-1:0]   op,
  output logic                        in_tready,
  input  strm_pkg::stat_t             stat,
  output strm_pkg::cmd_t              cmd
);

  strm_pkg::state_t state_r;
  strm_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= strm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      strm_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (op)
            strm_pkg::OP_LOAD: begin
              cmd.load_we = 1'b1;
            end
            strm_pkg::OP_BUILD: begin
              cmd.build_start = 1'b1;
              state_nxt       = strm_pkg::ST_BSTART;
            end
            strm_pkg::OP_QUERY: begin
              cmd.query_issue = 1'b1;
              state_nxt       = strm_pkg::ST_QDATA;
            end
            default: begin
              state_nxt = strm_pkg::ST_IDLE;
            end
          endcase
        end
      end
      strm_pkg::ST_QDATA: begin
        // Wait for room in the output register.
        if (stat.out_free) begin
          cmd.query_done = 1'b1;
          state_nxt      = strm_pkg::ST_IDLE;
        end
      end
      strm_pkg::ST_BSTART: begin
        if (stat.build_empty) begin
          cmd.build_finish = 1'b1;
          state_nxt        = strm_pkg::ST_IDLE;
        end else begin
          state_nxt = strm_pkg::ST_BRUN;
        end
      end
      strm_pkg::ST_BRUN: begin
        cmd.build_read = 1'b1;
        if (stat.build_last_j) state_nxt = strm_pkg::ST_BDRAIN;
      end
      strm_pkg::ST_BDRAIN: begin
        // The last entry of the level is written in this cycle.
        if (stat.build_last_lvl) begin
          cmd.build_finish = 1'b1;
          state_nxt        = strm_pkg::ST_IDLE;
        end else begin
          cmd.build_next = 1'b1;
          state_nxt      = strm_pkg::ST_BRUN;
        end
      end
      default: begin
        state_nxt = strm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/strm_dp.sv
// Datapath: level table memory, address generation, build pipeline and output register.
module strm_dp #(
  parameter int MAX_ELEMENTS = strm_pkg::MAX_ELEMENTS_DEF,
  parameter int LEVELS       = strm_pkg::LEVELS_DEF,
  parameter int VALUE_WIDTH  = strm_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  strm_pkg::cmd_t                cmd,
  output strm_pkg::stat_t               stat,
  input  logic                          cfg_we,
  input  logic [strm_pkg::CNT_W-1:0]    cfg_count,
  input  logic [strm_pkg::IDX_W-1:0]    load_index,
  input  logic [strm_pkg::VAL_W-1:0]    load_value,
  input  logic [strm_pkg::POS_W-1:0]    range_start,
  input  logic [strm_pkg::POS_W-1:0]    range_end,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output logic [strm_pkg::MIN_W-1:0]    out_minimum,
  output logic                          out_empty,
  output logic                          out_oor
);

  localparam int DW    = (VALUE_WIDTH < strm_pkg::MIN_W) ? VALUE_WIDTH : strm_pkg::MIN_W;
  localparam int IW    = $clog2(MAX_ELEMENTS);
  localparam int LW    = $clog2(LEVELS);
  localparam int BW    = $clog2(LEVELS + 1);
  localparam int NW    = ($clog2(MAX_ELEMENTS + 1) > strm_pkg::CNT_W) ?
                         $clog2(MAX_ELEMENTS + 1) : strm_pkg::CNT_W;
  localparam int NW1   = NW + 1;
  localparam int AW    = LW + IW;
  localparam int DEPTH = LEVELS * (2 ** IW);
  localparam int LGW   = strm_pkg::LOG_W;
  localparam int SW    = strm_pkg::SRCH_W;

  // Configuration register and effective element count.
  logic [strm_pkg::CNT_W-1:0] count_r;
  logic [NW-1:0]              count_w;
  logic [NW-1:0]              n_eff;
  logic [NW-1:0]              n_m1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= strm_pkg::CNT_W'(1024);
    end else if (cfg_we) begin
      count_r <= cfg_count;
    end
  end

  always_comb begin
    count_w = NW'(count_r);
    if (count_w == '0) begin
      n_eff = NW'(1);
    end else if (count_w > NW'(MAX_ELEMENTS)) begin
      n_eff = NW'(MAX_ELEMENTS);
    end else begin
      n_eff = count_w;
    end
    n_m1 = n_eff - NW'(1);
  end

  // Level table memory with one write and two registered read ports.
  logic [DW-1:0] mem [DEPTH];
  logic          we;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;
  logic [DW-1:0] rd_a_r;
  logic [DW-1:0] rd_b_r;
  logic [DW-1:0] rd_min;

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_min = (rd_a_r < rd_b_r) ? rd_a_r : rd_b_r;

  // Load address and bounds check.
  logic [NW-1:0] ld_wide;
  logic          ld_ok;
  logic [AW-1:0] ld_addr;

  assign ld_wide = NW'(load_index);
  assign ld_ok   = ld_wide < NW'(MAX_ELEMENTS);
  assign ld_addr = {LW'(0), ld_wide[IW-1:0]};

  // Query decode: flags, level and the two read addresses.
  logic [strm_pkg::POS_W-1:0] q_len;
  logic [LGW-1:0]             q_k;
  logic [NW-1:0]              q_start_w;
  logic [NW-1:0]              q_second_w;
  logic                       q_empty;
  logic                       q_beyond;
  logic                       q_unbuilt;
  logic [BW-1:0]              built_r;
  logic                       q_empty_r;
  logic                       q_oor_r;

  always_comb begin
    q_len      = range_end - range_start;
    q_k        = strm_pkg::floor_log2(SW'(q_len));
    q_start_w  = NW'(range_start);
    q_second_w = NW'(range_end) - (NW'(1) << q_k);
    q_empty    = range_end <= range_start;
    q_beyond   = NW'(range_end) > n_eff;
    q_unbuilt  = !q_empty && !q_beyond && (q_k >= LGW'(built_r));
  end

  always_ff @(posedge clk) begin
    if (cmd.query_issue) begin
      q_empty_r <= q_empty;
      q_oor_r   <= q_beyond | q_unbuilt;
    end
  end

  // Build sequencing registers.
  logic [LGW-1:0] clog_n;
  logic [LW-1:0]  top_r;
  logic [LW-1:0]  lvl_r;
  logic [IW-1:0]  j_r;
  logic [NW1-1:0] b_sum;
  logic [NW-1:0]  b_other;
  logic           bw_valid_r;
  logic [AW-1:0]  bw_addr_r;

  always_comb begin
    if (n_eff <= NW'(1)) begin
      clog_n = '0;
    end else begin
      clog_n = strm_pkg::floor_log2(SW'(n_m1)) + LGW'(1);
    end
    b_sum = NW1'(j_r) + (NW1'(1) << lvl_r);
    if (b_sum > NW1'(n_m1)) begin
      b_other = n_m1;
    end else begin
      b_other = b_sum[NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.build_start) begin
      if (clog_n > LGW'(LEVELS - 1)) begin
        top_r <= LW'(LEVELS - 1);
      end else begin
        top_r <= clog_n[LW-1:0];
      end
      lvl_r <= '0;
      j_r   <= '0;
    end else if (cmd.build_read) begin
      j_r <= j_r + IW'(1);
    end else if (cmd.build_next) begin
      lvl_r <= lvl_r + LW'(1);
      j_r   <= '0;
    end
  end

  // One-entry write pipeline: the minimum is written the cycle after its reads.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_valid_r <= 1'b0;
    end else begin
      bw_valid_r <= cmd.build_read;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.build_read) bw_addr_r <= {lvl_r + LW'(1), j_r};
  end

  // Number of usable levels.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      built_r <= BW'(1);
    end else if (cmd.build_finish) begin
      built_r <= BW'(top_r) + BW'(1);
    end
  end

  // Memory port steering.
  always_comb begin
    we        = bw_valid_r | (cmd.load_we & ld_ok);
    wr_addr   = bw_valid_r ? bw_addr_r : ld_addr;
    wr_data   = bw_valid_r ? rd_min : load_value[DW-1:0];
    rd_en     = cmd.query_issue | cmd.build_read;
    if (cmd.build_read) begin
      rd_addr_a = {lvl_r, j_r};
      rd_addr_b = {lvl_r, b_other[IW-1:0]};
    end else begin
      rd_addr_a = {q_k[LW-1:0], q_start_w[IW-1:0]};
      rd_addr_b = {q_k[LW-1:0], q_second_w[IW-1:0]};
    end
  end

  // Output register.
  logic                       out_valid_r;
  logic [strm_pkg::MIN_W-1:0] out_min_r;
  logic                       out_empty_r;
  logic                       out_oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.query_done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_done) begin
      if (q_empty_r || q_oor_r) begin
        out_min_r <= strm_pkg::MIN_W'({DW{1'b1}});
      end else begin
        out_min_r <= strm_pkg::MIN_W'(rd_min);
      end
      out_empty_r <= q_empty_r;
      out_oor_r   <= q_oor_r;
    end
  end

  assign out_tvalid  = out_valid_r;
  assign out_minimum = out_min_r;
  assign out_empty   = out_empty_r;
  assign out_oor     = out_oor_r;

  // Status toward the controller.
  always_comb begin
    stat.out_free       = !out_valid_r || out_tready;
    stat.build_empty    = top_r == '0;
    stat.build_last_j   = NW'(j_r) == n_m1;
    stat.build_last_lvl = LGW'(lvl_r) + LGW'(1) == LGW'(top_r);
  end

endmodule

// File: rtl/sparse_table_range_minimum.sv
// Top level of the sparse-table range-minimum engine.
//
//   Channel  Direction  Handshake             Payload
//   in_      slave      in_tvalid/in_tready   tuser: operation; tdata: index, value, range
//   out_     master     out_tvalid/out_tready tdata: minimum; tuser: range flags
//   cfg_     slave      cfg_valid/cfg_ready   cfg_data: element count
//
// A load writes its entry in the cycle it is accepted. A query reads both table entries in
// the cycle it is accepted, on the two read ports of the table memory, and fills the output
// register once that register has room. A build for n elements fills up to ceil(log2 n)
// levels, one entry per cycle within a level through the same memory, with a drain state between levels.
// Reset is synchronous and active low; the table keeps its contents and needs no clearing.
// A query whose result finds the output register still full waits there, holding in_tready low.
module sparse_table_range_minimum #(
  parameter int MAX_ELEMENTS = strm_pkg::MAX_ELEMENTS_DEF,
  parameter int LEVELS       = strm_pkg::LEVELS_DEF,
  parameter int VALUE_WIDTH  = strm_pkg::VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [9:0] load_index, [41:10] load_value, [52:42] range_start, [63:53] range_end
  input  logic [63:0] in_tdata,
  // [1:0] operation
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] minimum
  output logic [31:0] out_tdata,
  // [0] empty_range, [1] out_of_range
  output logic [1:0]  out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  strm_pkg::cmd_t  cmd;
  strm_pkg::stat_t stat;
  logic            out_empty;
  logic            out_oor;

  // The count register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  strm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .op        (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  strm_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LEVELS       (LEVELS),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_count   (cfg_data),
    .load_index  (in_tdata[9:0]),
    .load_value  (in_tdata[41:10]),
    .range_start (in_tdata[52:42]),
    .range_end   (in_tdata[63:53]),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_minimum (out_tdata),
    .out_empty   (out_empty),
    .out_oor     (out_oor)
  );

  assign out_tuser = {out_oor, out_empty};

endmodule
